/* design/slot_allocator_with_wait_queue_macros.svh */
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Shared property wrappers; ASSERT_OFF compiles them away.
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_WITH_WAIT_QUEUE_MACROS_SVH
`define SLOT_ALLOCATOR_WITH_WAIT_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SLA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot allocator check failed");
// next-cycle implication
`define SLA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot allocator check failed");
`else
`define SLA_ASSERT_IMP(lbl, ante, cons)
`define SLA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* design/sla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator package
// Sizes, derived widths, request and status codes shared by all modules.
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int WAIT_DEPTH = 16;
  localparam int ID_WIDTH   = 16;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int WIDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);

  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [SLOT_W-1:0]   slot_idx_t;
  typedef logic [WIDX_W-1:0]   widx_t;
  typedef logic [CNT_W-1:0]    wcnt_t;

  // request codes
  localparam logic [1:0] ACT_BOOK   = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  // result status codes
  localparam logic [2:0] ST_BOOKED     = 3'd0;
  localparam logic [2:0] ST_WAITLISTED = 3'd1;
  localparam logic [2:0] ST_REJECTED   = 3'd2;
  localparam logic [2:0] ST_FREED      = 3'd3;
  localparam logic [2:0] ST_REASSIGNED = 3'd4;
  localparam logic [2:0] ST_INVALID    = 3'd5;
  localparam logic [2:0] ST_FOUND      = 3'd6;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd7;

  // Take the low ID_WIDTH bits of a 16-bit ticket, zero-extending if wider.
  function automatic id_t to_id(input logic [15:0] ticket);
    logic [31:0] w;
    w = 32'(ticket);
    return w[ID_WIDTH-1:0];
  endfunction

endpackage

/* design/slot_allocator_with_wait_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator with wait queue
// Books ids into the lowest free slot, queues them when full, frees and
// reseats slots on cancel, and searches for an id.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_action, in_ticket_id, in_slot_number) are taken when
//   in_valid is high and in_stall is low. Every word yields exactly one
//   result word on the out_ channel, held until out_stall is low.
//   The slot table lives in a ring of NUM_SLOTS cells. Each request rotates
//   the ring once, one slot passing the compare point per cycle, so a word
//   passes through an accept state, a scan of every slot and a finish
//   state: the result is registered in the finish state, and a new word
//   is taken only once the finish state is left, one word at a time.
//   The waitlist is updated in the finish cycle.
//   A new word may be accepted while the previous result still waits;
//   if the receiver stalls, the next result is held in the finish cycle
//   until the output register frees up.
//   Reset (rst_n low, synchronous) frees every slot and empties the
//   waitlist; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "slot_allocator_with_wait_queue_macros.svh"

module slot_allocator_with_wait_queue
  import sla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_ticket_id,
  input  logic [4:0]  in_slot_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot_out,
  output logic [15:0] out_id_out,
  output logic [4:0]  out_waiting_count
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  localparam slot_idx_t LAST_SLOT = slot_idx_t'(NUM_SLOTS - 1);

  state_t      state_r;
  logic [1:0]  action_r;
  id_t         id_r;
  logic [4:0]  slot_r;
  slot_idx_t   cnt_r;
  logic        found_r;
  slot_idx_t   pos_r;
  id_t         hold_id_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [3:0]  out_slot_r;
  logic [15:0] out_id_r;
  logic [4:0]  out_wc_r;

  id_t   cell_q [NUM_SLOTS];
  id_t   q0;
  id_t   tail_d;
  id_t   wr_val;
  logic  shift_en;
  logic  at_slot;
  logic  book_hit, srch_hit, canc_hit, wr_en;
  logic  in_accept, out_free;

  id_t   fifo_head;
  wcnt_t fifo_count;
  logic  fifo_push, fifo_pop;
  wcnt_t wc_nxt;

  logic [2:0]  fin_status;
  logic [31:0] fin_slot_w;
  logic [31:0] fin_id_w;
  logic [31:0] wc_w;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign shift_en  = (state_r == S_SCAN);

  // ring of slot cells; the last cell takes cell 0's id or a new one
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    if (i == NUM_SLOTS - 1) begin : g_last
      sla_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift_en(shift_en),
        .d_in    (tail_d),
        .q       (cell_q[i])
      );
    end else begin : g_mid
      sla_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift_en(shift_en),
        .d_in    (cell_q[i+1]),
        .q       (cell_q[i])
      );
    end
  end

  sla_wait_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_data(id_r),
    .pop      (fifo_pop),
    .head_data(fifo_head),
    .count    (fifo_count)
  );

  // compare point: slot cnt_r sits in cell 0 during the scan
  always_comb begin
    q0       = cell_q[0];
    at_slot  = (32'(cnt_r) == 32'(slot_r));
    book_hit = shift_en && (action_r == ACT_BOOK) && (id_r != '0) && !found_r
               && (q0 == '0);
    srch_hit = shift_en && (action_r == ACT_SEARCH) && !found_r && (q0 == id_r);
    canc_hit = shift_en && (action_r == ACT_CANCEL) && at_slot && (q0 != '0);
    wr_en    = book_hit || canc_hit;
    wr_val   = book_hit ? id_r : ((fifo_count != '0) ? fifo_head : '0);
    tail_d   = wr_en ? wr_val : q0;
  end

  // finish: waitlist update and result fields
  always_comb begin
    fifo_push  = 1'b0;
    fifo_pop   = 1'b0;
    fin_status = ST_INVALID;
    fin_slot_w = '0;
    fin_id_w   = '0;
    if ((state_r == S_FINISH) && out_free) begin
      unique case (action_r)
        ACT_BOOK: begin
          priority if (found_r) begin
            fin_status = ST_BOOKED;
            fin_slot_w = 32'(pos_r);
          end else if ((id_r != '0) && (32'(fifo_count) < WAIT_DEPTH)) begin
            fin_status = ST_WAITLISTED;
            fifo_push  = 1'b1;
          end else begin
            fin_status = ST_REJECTED;
          end
        end
        ACT_CANCEL: begin
          if (found_r) begin
            fin_status = (fifo_count != '0) ? ST_REASSIGNED : ST_FREED;
            fifo_pop   = (fifo_count != '0);
            fin_slot_w = 32'(pos_r);
            fin_id_w   = 32'(hold_id_r);
          end
        end
        ACT_SEARCH: begin
          if (found_r) begin
            fin_status = ST_FOUND;
            fin_slot_w = 32'(pos_r);
          end else begin
            fin_status = ST_NOT_FOUND;
          end
        end
        default: begin
          fin_status = ST_INVALID;
        end
      endcase
    end
    wc_nxt = fifo_count + wcnt_t'(fifo_push) - wcnt_t'(fifo_pop);
    wc_w   = 32'(wc_nxt);
  end

  // sequencer: hold request, step the scan, load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // drop a taken result unless the finish cycle loads a new one
      if (out_valid_r && !out_stall && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            action_r <= in_action;
            id_r     <= to_id(in_ticket_id);
            slot_r   <= in_slot_number;
            found_r  <= 1'b0;
            cnt_r    <= '0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (book_hit || srch_hit || canc_hit) begin
            found_r <= 1'b1;
            pos_r   <= cnt_r;
          end
          if (canc_hit) begin
            hold_id_r <= (fifo_count != '0) ? fifo_head : q0;
          end
          if (cnt_r == LAST_SLOT) begin
            cnt_r   <= '0;
            state_r <= S_FINISH;
          end else begin
            cnt_r <= cnt_r + slot_idx_t'(1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= fin_status;
            out_slot_r   <= fin_slot_w[3:0];
            out_id_r     <= fin_id_w[15:0];
            out_wc_r     <= wc_w[4:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_out      = out_slot_r;
  assign out_id_out        = out_id_r;
  assign out_waiting_count = out_wc_r;

  // checks
  `SLA_ASSERT_IMP(a_fifo_bound, 1'b1, 32'(fifo_count) <= WAIT_DEPTH)
  `SLA_ASSERT_IMP(a_push_room, fifo_push, 32'(fifo_count) < WAIT_DEPTH)
  `SLA_ASSERT_IMP(a_pop_nonempty, fifo_pop, fifo_count != '0)
  `SLA_ASSERT_NXT(a_accept_scan, in_accept, state_r == S_SCAN && cnt_r == '0)
  `SLA_ASSERT_IMP(a_one_write, wr_en, !(book_hit && canc_hit))

endmodule

/* design/sla_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot cell
// Holds the id of one slot of the ring; shifts to its neighbor when enabled.
// ----------------------------------------------------------------------------
module sla_cell
  import sla_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic shift_en,
  input  id_t  d_in,
  output id_t  q
);

  id_t id_r;

  // clear to free at reset, take neighbor's id while the ring rotates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r <= '0;
    end else if (shift_en) begin
      id_r <= d_in;
    end
  end

  assign q = id_r;

endmodule

/* design/sla_wait_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wait FIFO
// Circular waitlist of ids with registered head read.
// ----------------------------------------------------------------------------
module sla_wait_fifo
  import sla_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  id_t   push_data,
  input  logic  pop,
  output id_t   head_data,
  output wcnt_t count
);

  id_t   mem [WAIT_DEPTH];
  widx_t head_r;
  wcnt_t count_r;
  id_t   head_data_r;
  widx_t tail;
  logic [WIDX_W:0] tail_sum;

  // tail = (head + count) mod depth; the sum stays below twice the depth
  always_comb begin
    tail_sum = (WIDX_W+1)'(head_r) + (WIDX_W+1)'(count_r);
    if (32'(tail_sum) >= WAIT_DEPTH) begin
      tail_sum = tail_sum - (WIDX_W+1)'(WAIT_DEPTH);
    end
    tail = tail_sum[WIDX_W-1:0];
  end

  // write the tail entry, read the head entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    head_data_r <= mem[head_r];
  end

  // advance head and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      if (pop) begin
        head_r <= (32'(head_r) == WAIT_DEPTH - 1) ? '0 : head_r + widx_t'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + wcnt_t'(1);
      end else if (pop && !push) begin
        count_r <= count_r - wcnt_t'(1);
      end
    end
  end

  assign head_data = head_data_r;
  assign count     = count_r;

endmodule

/* tb/slot_allocator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator checker
// Watches the request and result channels, keeps its own slot table and
// waitlist, predicts one result word per accepted request word and compares
// each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module slot_allocator_checker
  import sla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_ticket_id,
  input  logic [4:0]  in_slot_number,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_slot_out,
  input  logic [15:0] out_id_out,
  input  logic [4:0]  out_waiting_count,
  output int          mismatch_total,
  output int          results_owed
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] id;
    logic [4:0]  waiting;
  } outcome_t;

  // shadow copy of the slot table and the waitlist
  id_t      seats [NUM_SLOTS];
  id_t      waiters [$];
  outcome_t owed_outcomes [$];
  int       mismatches = 0;

  assign mismatch_total = mismatches;
  assign results_owed   = owed_outcomes.size();

  // lowest slot holding the id, NUM_SLOTS when none does
  function automatic int lowest_holder(id_t id);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (seats[i] == id) return i;
    end
    return NUM_SLOTS;
  endfunction

  // apply one request word to the shadow state and return its result word
  function automatic outcome_t predict_outcome(logic [1:0] action, logic [15:0] ticket,
                                               logic [4:0] slot_req);
    outcome_t res;
    id_t      id;
    id_t      old_id;
    int       pos;
    res = '0;
    id  = id_t'(ticket);
    case (action)
      ACT_BOOK: begin
        if (id == '0) begin
          res.status = ST_REJECTED;
        end else begin
          pos = lowest_holder('0);
          if (pos < NUM_SLOTS) begin
            seats[pos] = id;
            res.status = ST_BOOKED;
            res.slot   = 4'(pos);
          end else if (waiters.size() < WAIT_DEPTH) begin
            waiters.push_back(id);
            res.status = ST_WAITLISTED;
          end else begin
            res.status = ST_REJECTED;
          end
        end
      end
      ACT_CANCEL: begin
        if (slot_req >= NUM_SLOTS || seats[slot_req] == '0) begin
          res.status = ST_INVALID;
        end else begin
          old_id = seats[slot_req];
          res.slot = slot_req[3:0];
          // hand the freed slot straight to the oldest waiter
          if (waiters.size() != 0) begin
            seats[slot_req] = waiters.pop_front();
            res.status = ST_REASSIGNED;
            res.id     = 16'(seats[slot_req]);
          end else begin
            seats[slot_req] = '0;
            res.status = ST_FREED;
            res.id     = 16'(old_id);
          end
        end
      end
      ACT_SEARCH: begin
        pos = lowest_holder(id);
        if (pos < NUM_SLOTS) begin
          res.status = ST_FOUND;
          res.slot   = 4'(pos);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    res.waiting = 5'(waiters.size());
    return res;
  endfunction

  // compare result words first, then log the prediction for a new request word
  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) seats[i] = '0;
      waiters.delete();
      owed_outcomes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_status, out_slot_out, out_id_out, out_waiting_count};
        if (owed_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result word with none expected: status %0d slot %0d id %h wait %0d",
                     $realtime, seen.status, seen.slot, seen.id, seen.waiting);
        end else begin
          want = owed_outcomes.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"%0t: result mismatch: status exp %0d got %0d, slot exp %0d got %0d, ",
                        "id exp %h got %h, wait exp %0d got %0d"}, $realtime,
                       want.status, seen.status, want.slot, seen.slot,
                       want.id, seen.id, want.waiting, seen.waiting);
          end
        end
      end
      if (in_valid && !in_stall)
        owed_outcomes.push_back(predict_outcome(in_action, in_ticket_id, in_slot_number));
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator testbench top
// Drives directed and random request words with random sender gaps and
// receiver stalls, runs a quiet-cycle watchdog and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import sla_pkg::*;

  localparam int RANDOM_PER_PHASE = 667;
  localparam int BIAS_RUN         = 48;
  localparam int DRAIN_CYCLES     = 2 * (NUM_SLOTS + 2);
  localparam int WATCHDOG_LIMIT   = 2000;

  // request code with no meaning, answered as an invalid request
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [15:0] in_ticket_id = '0;
  logic [4:0]  in_slot_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_slot_out;
  logic [15:0] out_id_out;
  logic [4:0]  out_waiting_count;

  int mismatch_total;
  int results_owed;
  int send_idle_pct = 13;
  int recv_idle_pct = 59;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  slot_allocator_with_wait_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_ticket_id      (in_ticket_id),
    .in_slot_number    (in_slot_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot_out      (out_slot_out),
    .out_id_out        (out_id_out),
    .out_waiting_count (out_waiting_count)
  );

  slot_allocator_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_ticket_id      (in_ticket_id),
    .in_slot_number    (in_slot_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot_out      (out_slot_out),
    .out_id_out        (out_id_out),
    .out_waiting_count (out_waiting_count),
    .mismatch_total    (mismatch_total),
    .results_owed      (results_owed)
  );

  // stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // end the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request word after a random gap; return at the falling edge after accept
  task automatic send_word(logic [1:0] action, logic [15:0] ticket, logic [4:0] slot_req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= action;
    in_ticket_id   <= ticket;
    in_slot_number <= slot_req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int          pick;
    int          book_pct;
    int          cancel_pct;
    logic [1:0]  act;
    logic [15:0] ticket;
    logic [4:0]  slot_req;

    // hold reset, release it away from the rising edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words: id zero, bad cancels, unused code, id extremes, duplicates
    send_word(ACT_BOOK,   16'h0000, 5'd0);
    send_word(ACT_SEARCH, 16'h0000, 5'd0);
    send_word(ACT_CANCEL, 16'h0000, 5'd0);
    send_word(ACT_CANCEL, 16'hffff, 5'd31);
    send_word(ACT_CANCEL, 16'h0000, 5'd16);
    send_word(ACT_UNUSED, 16'hffff, 5'd31);
    send_word(ACT_BOOK,   16'h0001, 5'd31);
    send_word(ACT_BOOK,   16'hffff, 5'd0);
    send_word(ACT_SEARCH, 16'hffff, 5'd31);
    send_word(ACT_SEARCH, 16'h0001, 5'd0);
    send_word(ACT_SEARCH, 16'h1234, 5'd0);
    send_word(ACT_CANCEL, 16'hffff, 5'd0);
    send_word(ACT_BOOK,   16'h8000, 5'd0);
    send_word(ACT_BOOK,   16'hffff, 5'd0);
    send_word(ACT_SEARCH, 16'hffff, 5'd0);
    send_word(ACT_CANCEL, 16'h0000, 5'd15);
    send_word(ACT_CANCEL, 16'h0000, 5'd1);
    send_word(ACT_SEARCH, 16'hffff, 5'd0);
    send_word(ACT_UNUSED, 16'h0000, 5'd0);

    // random words in three idling phases; alternate fill and drain runs
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        book_pct   = (((n / BIAS_RUN) % 2) == 0) ? 68 : 28;
        cancel_pct = (((n / BIAS_RUN) % 2) == 0) ? 15 : 50;
        pick       = $urandom_range(99);
        ticket     = 16'($urandom());
        slot_req   = 5'($urandom_range(31));
        if (pick < 3) begin
          act = ACT_UNUSED;
        end else if (pick < 3 + book_pct) begin
          act = ACT_BOOK;
          pick = $urandom_range(99);
          if (pick < 70) ticket = 16'($urandom_range(40, 1));
          else if (pick < 75) ticket = 16'h0000;
        end else if (pick < 3 + book_pct + cancel_pct) begin
          act = ACT_CANCEL;
          if ($urandom_range(99) < 85) slot_req = 5'($urandom_range(NUM_SLOTS - 1));
        end else begin
          act = ACT_SEARCH;
          pick = $urandom_range(99);
          if (pick < 60) ticket = 16'($urandom_range(40, 1));
          else if (pick < 70) ticket = 16'h0000;
        end
        send_word(act, ticket, slot_req);
      end
    end
    in_valid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_total == 0 && results_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
